@@ sv/boris_velocity_push_core_macros.svh @@
// ----------------------------------------------------------------------------
// boris_velocity_push_core_macros
// Assertion macros used by the velocity push core RTL.
// ----------------------------------------------------------------------------
`ifndef BORIS_VELOCITY_PUSH_CORE_MACROS_SVH
`define BORIS_VELOCITY_PUSH_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BVP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BVP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/bvp_pkg.sv @@
// ----------------------------------------------------------------------------
// bvp_pkg
// Types, constants and fixed-point helpers of the Boris velocity push.
// ----------------------------------------------------------------------------
package bvp_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int PROD_W     = 2 * DATA_WIDTH;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_Q_OVER_M  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEP = 1'd1;

   localparam logic [1:0] KIND_FULL = 2'd0;
   localparam logic [1:0] KIND_INIT = 2'd1;
   localparam logic [1:0] KIND_SYNC = 2'd2;

   // Divider: den = 1.0 + |t|^2, quotient of 2^(2F+1) + den/2 never exceeds 2^(F+1).
   localparam int DEN_W      = DATA_WIDTH + 1;
   localparam int NUM_W      = 2 * FRAC_BITS + 2;
   localparam int QUO_BITS   = FRAC_BITS + 2;
   localparam int CMP_W      = DEN_W + QUO_BITS;
   localparam int DIV_STAGES = QUO_BITS;

   // Pipeline stage numbering.
   localparam int ST_H    = 0;
   localparam int ST_KICK = 1;
   localparam int ST_PROD = 2;
   localparam int ST_DEN  = 3;
   localparam int ST_DIV0 = 4;
   localparam int ST_S    = ST_DIV0 + DIV_STAGES;
   localparam int ST_ROT  = ST_S + 1;
   localparam int ST_OUT  = ST_ROT + 1;
   localparam int NSTG    = ST_OUT + 1;

   typedef logic signed [DATA_WIDTH-1:0] word_type;
   typedef word_type [2:0] vec_type;
   typedef logic [DEN_W-1:0] den_type;
   typedef logic [QUO_BITS-1:0] quo_type;

   localparam quo_type QUO_MAX = quo_type'(1) << (FRAC_BITS + 1);

   typedef struct packed {
      vec_type vm;
      vec_type t;
      vec_type eh;
      vec_type vp;
   } side_type;

   localparam logic signed [PROD_W-1:0] VMAX = PROD_W'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
   localparam word_type WMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam word_type WMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   function automatic word_type sat_add(input word_type a, input word_type b);
      logic signed [DATA_WIDTH:0] s;
      s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
      if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
         return s[DATA_WIDTH] ? WMIN : WMAX;
      end
      return s[DATA_WIDTH-1:0];
   endfunction

   function automatic word_type sat_sub(input word_type a, input word_type b);
      logic signed [DATA_WIDTH:0] s;
      s = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
      if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
         return s[DATA_WIDTH] ? WMIN : WMAX;
      end
      return s[DATA_WIDTH-1:0];
   endfunction

   // Exact product, magnitude rounded half away from zero, then saturated.
   function automatic word_type mulsh(input word_type a, input word_type b,
                                      input int unsigned sh);
      logic signed [PROD_W-1:0] p;
      logic [PROD_W-1:0] mag;
      logic [PROD_W-1:0] r;
      logic neg;
      p   = PROD_W'(a) * PROD_W'(b);
      neg = a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
      mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
      r   = (mag + (PROD_W'(1) << (sh - 1))) >> sh;
      if (r > VMAX) begin
         return neg ? WMIN : WMAX;
      end
      return neg ? word_type'(-r[DATA_WIDTH-1:0]) : word_type'(r[DATA_WIDTH-1:0]);
   endfunction

   function automatic word_type qmul(input word_type a, input word_type b);
      return mulsh(a, b, FRAC_BITS);
   endfunction

endpackage

@@ sv/bvp_if.sv @@
// ----------------------------------------------------------------------------
// bvp_req_if / bvp_rsp_if
// Valid/ready channels for particle requests and pushed velocities.
// ----------------------------------------------------------------------------
interface bvp_req_if;
   import bvp_pkg::*;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   word_type   vel_in_x;
   word_type   vel_in_y;
   word_type   vel_in_z;
   word_type   e_x;
   word_type   e_y;
   word_type   e_z;
   word_type   b_x;
   word_type   b_y;
   word_type   b_z;
   modport source (output valid, req_type, vel_in_x, vel_in_y, vel_in_z,
                   e_x, e_y, e_z, b_x, b_y, b_z, input ready);
   modport sink (input valid, req_type, vel_in_x, vel_in_y, vel_in_z,
                 e_x, e_y, e_z, b_x, b_y, b_z, output ready);
endinterface

interface bvp_rsp_if;
   import bvp_pkg::*;
   logic     valid;
   logic     ready;
   word_type vel_out_x;
   word_type vel_out_y;
   word_type vel_out_z;
   modport source (output valid, vel_out_x, vel_out_y, vel_out_z, input ready);
   modport sink (input valid, vel_out_x, vel_out_y, vel_out_z, output ready);
endinterface

@@ sv/bvp_div.sv @@
// ----------------------------------------------------------------------------
// bvp_div
// Pipelined restoring divider for f = (2^(2F+1) + den/2) / den, one bit a stage.
// ----------------------------------------------------------------------------
module bvp_div (
   input  logic                                clock,
   input  logic [bvp_pkg::DIV_STAGES-1:0]      en,
   input  bvp_pkg::den_type                    den,
   output bvp_pkg::quo_type                    quo
);
   import bvp_pkg::*;

   logic [NUM_W-1:0] rem_ff [DIV_STAGES];
   den_type          den_ff [DIV_STAGES];
   quo_type          quo_ff [DIV_STAGES];

   logic [NUM_W-1:0] num_in;
   assign num_in = (NUM_W'(1) << (2 * FRAC_BITS + 1)) + NUM_W'(den >> 1);

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      localparam int BIT = DIV_STAGES - 1 - k;
      logic [NUM_W-1:0] rem_src;
      den_type          den_src;
      quo_type          quo_src;
      logic [CMP_W-1:0] dsh;
      logic             take;
      logic [NUM_W-1:0] rem_in;
      quo_type          quo_in;

      if (k == 0) begin : g_first
         assign rem_src = num_in;
         assign den_src = den;
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[k-1];
         assign den_src = den_ff[k-1];
         assign quo_src = quo_ff[k-1];
      end

      always_comb begin
         dsh    = CMP_W'(den_src) << BIT;
         take   = CMP_W'(rem_src) >= dsh;
         rem_in = take ? NUM_W'(CMP_W'(rem_src) - dsh) : rem_src;
         quo_in = quo_src;
         quo_in[BIT] = take;
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_src;
            quo_ff[k] <= quo_in;
         end
      end
   end

   assign quo = quo_ff[DIV_STAGES-1];

endmodule

@@ sv/boris_velocity_push_core.sv @@
// ----------------------------------------------------------------------------
// boris_velocity_push_core
// Boris velocity push in signed Q16.16: half kick, magnetic rotation, half kick.
// ----------------------------------------------------------------------------
//  channel  direction  content
//  req      in         step kind, velocity, E and B at the particle
//  rsp      out        pushed velocity, saturated
//  csr      in         charge/mass ratio (index 0), time_step (index 1)
//
// The pipeline has 25 register stages: four for h, the first kick, the squares
// and cross products and the divisor, the 18 one-bit stages of the 2/(1+|t|^2)
// divider, and three for s, the second rotation and the output. One transaction
// is accepted per cycle unless a stall at rsp backs the full pipeline up. Each
// stage holds unless the one after it is empty or moving, so bubbles close up
// under a stall.
// Synchronous reset empties the pipeline and loads both registers with 1.0.
module boris_velocity_push_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [bvp_pkg::CSR_IDX_W-1:0] csr_index,
   input  bvp_pkg::word_type           csr_wdata,
   bvp_req_if.sink                     req,
   bvp_rsp_if.source                   rsp
);
   import bvp_pkg::*;
`include "boris_velocity_push_core_macros.svh"

   word_type qm_ff, dt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         qm_ff <= word_type'(1 << FRAC_BITS);
         dt_ff <= word_type'(1 << FRAC_BITS);
      end else if (csr_we) begin
         case (csr_index)
            CSR_Q_OVER_M:  qm_ff <= csr_wdata;
            CSR_TIME_STEP: dt_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage advance chain.
   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] adv;

   always_comb begin
      adv[NSTG-1] = !vld_ff[NSTG-1] || rsp.ready;
      for (int k = NSTG - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= req.valid;
         end
         for (int k = 1; k < NSTG; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   assign req.ready = adv[ST_H];

   // Stage H: effective h for the step kind.
   word_type h_in, h_ff;
   vec_type  v0_ff, e0_ff, b0_ff;

   always_comb begin
      case (req.req_type)
         KIND_INIT: h_in = sat_sub('0, mulsh(qm_ff, dt_ff, FRAC_BITS + 2));
         KIND_SYNC: h_in = mulsh(qm_ff, dt_ff, FRAC_BITS + 2);
         default:   h_in = mulsh(qm_ff, dt_ff, FRAC_BITS + 1);
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv[ST_H]) begin
         h_ff  <= h_in;
         v0_ff <= {req.vel_in_z, req.vel_in_y, req.vel_in_x};
         e0_ff <= {req.e_z, req.e_y, req.e_x};
         b0_ff <= {req.b_z, req.b_y, req.b_x};
      end
   end

   // Stage KICK: first half kick and t.
   vec_type vm1_ff, t1_ff, eh1_ff;

   always_ff @(posedge clock) begin
      if (adv[ST_KICK]) begin
         for (int i = 0; i < 3; i++) begin
            eh1_ff[i] <= qmul(e0_ff[i], h_ff);
            vm1_ff[i] <= sat_add(v0_ff[i], qmul(e0_ff[i], h_ff));
            t1_ff[i]  <= qmul(b0_ff[i], h_ff);
         end
      end
   end

   // Stage PROD: squares of t and the products of vm x t.
   vec_type tt2_ff, pa2_ff, pb2_ff, vm2_ff, t2_ff, eh2_ff;

   always_ff @(posedge clock) begin
      if (adv[ST_PROD]) begin
         for (int i = 0; i < 3; i++) begin
            tt2_ff[i] <= qmul(t1_ff[i], t1_ff[i]);
         end
         pa2_ff[0] <= qmul(vm1_ff[1], t1_ff[2]);
         pb2_ff[0] <= qmul(vm1_ff[2], t1_ff[1]);
         pa2_ff[1] <= qmul(vm1_ff[2], t1_ff[0]);
         pb2_ff[1] <= qmul(vm1_ff[0], t1_ff[2]);
         pa2_ff[2] <= qmul(vm1_ff[0], t1_ff[1]);
         pb2_ff[2] <= qmul(vm1_ff[1], t1_ff[0]);
         vm2_ff <= vm1_ff;
         t2_ff  <= t1_ff;
         eh2_ff <= eh1_ff;
      end
   end

   // Stage DEN: divisor 1 + |t|^2 and vp = vm + vm x t.
   word_type tsq_in;
   den_type  den_ff;
   side_type side3_ff;

   always_comb begin
      tsq_in = sat_add(sat_add(tt2_ff[0], tt2_ff[1]), tt2_ff[2]);
      if (tsq_in[DATA_WIDTH-1]) begin
         tsq_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_DEN]) begin
         den_ff <= (DEN_W'(1) << FRAC_BITS) + DEN_W'(unsigned'(tsq_in));
         for (int i = 0; i < 3; i++) begin
            side3_ff.vp[i] <= sat_add(vm2_ff[i], sat_sub(pa2_ff[i], pb2_ff[i]));
         end
         side3_ff.vm <= vm2_ff;
         side3_ff.t  <= t2_ff;
         side3_ff.eh <= eh2_ff;
      end
   end

   // Divider stages with the side data running alongside.
   quo_type  quo;
   side_type sided_ff [DIV_STAGES];

   bvp_div u_div (
      .clock (clock),
      .en    (adv[ST_DIV0 +: DIV_STAGES]),
      .den   (den_ff),
      .quo   (quo)
   );

   always_ff @(posedge clock) begin
      if (adv[ST_DIV0]) begin
         sided_ff[0] <= side3_ff;
      end
      for (int j = 1; j < DIV_STAGES; j++) begin
         if (adv[ST_DIV0 + j]) begin
            sided_ff[j] <= sided_ff[j-1];
         end
      end
   end

   // Stage S: s = f * t.
   vec_type s5_ff, vm5_ff, eh5_ff, vp5_ff;
   word_type f_w;
   assign f_w = word_type'(quo);

   always_ff @(posedge clock) begin
      if (adv[ST_S]) begin
         for (int i = 0; i < 3; i++) begin
            s5_ff[i] <= qmul(sided_ff[DIV_STAGES-1].t[i], f_w);
         end
         vm5_ff <= sided_ff[DIV_STAGES-1].vm;
         eh5_ff <= sided_ff[DIV_STAGES-1].eh;
         vp5_ff <= sided_ff[DIV_STAGES-1].vp;
      end
   end

   // Stage ROT: products of vp x s.
   vec_type pa6_ff, pb6_ff, vm6_ff, eh6_ff;

   always_ff @(posedge clock) begin
      if (adv[ST_ROT]) begin
         pa6_ff[0] <= qmul(vp5_ff[1], s5_ff[2]);
         pb6_ff[0] <= qmul(vp5_ff[2], s5_ff[1]);
         pa6_ff[1] <= qmul(vp5_ff[2], s5_ff[0]);
         pb6_ff[1] <= qmul(vp5_ff[0], s5_ff[2]);
         pa6_ff[2] <= qmul(vp5_ff[0], s5_ff[1]);
         pb6_ff[2] <= qmul(vp5_ff[1], s5_ff[0]);
         vm6_ff <= vm5_ff;
         eh6_ff <= eh5_ff;
      end
   end

   // Stage OUT: v+ and the second half kick.
   vec_type out_ff;

   always_ff @(posedge clock) begin
      if (adv[ST_OUT]) begin
         for (int i = 0; i < 3; i++) begin
            out_ff[i] <= sat_add(sat_add(vm6_ff[i], sat_sub(pa6_ff[i], pb6_ff[i])),
                                 eh6_ff[i]);
         end
      end
   end

   assign rsp.valid     = vld_ff[ST_OUT];
   assign rsp.vel_out_x = out_ff[0];
   assign rsp.vel_out_y = out_ff[1];
   assign rsp.vel_out_z = out_ff[2];

   `BVP_ASSERT_NEXT(a_accept_enters, req.valid && req.ready, vld_ff[ST_H], "transaction lost")
   `BVP_ASSERT_NOW(a_empty_ready, vld_ff == '0, req.ready, "idle core not ready")
   `BVP_ASSERT_NEXT(a_rot_to_out, vld_ff[ST_ROT] && adv[ST_ROT], vld_ff[ST_OUT], "result lost")
   `BVP_ASSERT_NOW(a_quo_range, vld_ff[ST_S - 1], quo <= QUO_MAX, "quotient out of range")

endmodule

@@ sim/bvp_tb_if.sv @@
// ----------------------------------------------------------------------------
// bvp_tb_pkg
// Particle and pushed-velocity records used by the testbench scoreboard.
// ----------------------------------------------------------------------------
package bvp_tb_pkg;
   import bvp_pkg::*;

   typedef struct {
      logic [1:0] kind;
      word_type   v[3];
      word_type   e[3];
      word_type   b[3];
   } particle_type;

   typedef struct {
      word_type v[3];
   } pushed_type;
endpackage

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// Boris velocity push testbench
// Streams particles with random valid and ready gaps through the core, predicts
// each pushed velocity in fixed point and compares it, field by field, in order.
// ----------------------------------------------------------------------------
class push_scoreboard;
   bvp_tb_pkg::pushed_type pending_q[$];
   logic signed [31:0] qm = 32'sd65536;
   logic signed [31:0] dt = 32'sd65536;
   int errors;
   int checked;

   // Exact product, shifted, magnitude rounded half away from zero, saturated.
   function automatic logic signed [31:0] prod_shift(logic signed [31:0] a,
                                                     logic signed [31:0] b, int sh);
      logic signed [63:0] p;
      logic [63:0] mag;
      logic [63:0] r;
      logic neg;
      p = 64'(a) * 64'(b);
      neg = a[31] ^ b[31];
      mag = p[63] ? 64'(-p) : 64'(p);
      r = (mag >> sh) + ((mag >> (sh - 1)) & 64'd1);
      if (r > 64'h7fff_ffff) return neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
      return neg ? -$signed(r[31:0]) : $signed(r[31:0]);
   endfunction

   function automatic logic signed [31:0] clip_add(logic signed [31:0] a,
                                                   logic signed [31:0] b);
      logic signed [32:0] s;
      s = 33'(a) + 33'(b);
      if (s > 33'sh0_7fff_ffff) return 32'sh7fff_ffff;
      if (s < -33'sh0_8000_0000) return 32'sh8000_0000;
      return s[31:0];
   endfunction

   function automatic logic signed [31:0] clip_sub(logic signed [31:0] a,
                                                   logic signed [31:0] b);
      logic signed [32:0] s;
      s = 33'(a) - 33'(b);
      if (s > 33'sh0_7fff_ffff) return 32'sh7fff_ffff;
      if (s < -33'sh0_8000_0000) return 32'sh8000_0000;
      return s[31:0];
   endfunction

   function automatic void cross_prod(input logic signed [31:0] a[3],
                                      input logic signed [31:0] b[3],
                                      output logic signed [31:0] c[3]);
      c[0] = clip_sub(prod_shift(a[1], b[2], 16), prod_shift(a[2], b[1], 16));
      c[1] = clip_sub(prod_shift(a[2], b[0], 16), prod_shift(a[0], b[2], 16));
      c[2] = clip_sub(prod_shift(a[0], b[1], 16), prod_shift(a[1], b[0], 16));
   endfunction

   function automatic bvp_tb_pkg::pushed_type push(bvp_tb_pkg::particle_type p);
      bvp_tb_pkg::pushed_type res;
      logic signed [31:0] h, t2, f;
      logic signed [31:0] vm[3], t[3], s[3], c[3], vp[3], eh[3];
      logic [63:0] den, fq;
      if (p.kind == bvp_pkg::KIND_INIT) h = clip_sub(0, prod_shift(qm, dt, 18));
      else if (p.kind == bvp_pkg::KIND_SYNC) h = prod_shift(qm, dt, 18);
      else h = prod_shift(qm, dt, 17);
      for (int i = 0; i < 3; i++) begin
         eh[i] = prod_shift(p.e[i], h, 16);
         vm[i] = clip_add(p.v[i], eh[i]);
         t[i] = prod_shift(p.b[i], h, 16);
      end
      t2 = clip_add(clip_add(prod_shift(t[0], t[0], 16), prod_shift(t[1], t[1], 16)),
                    prod_shift(t[2], t[2], 16));
      if (t2 < 0) t2 = 0;
      den = 64'd65536 + 64'(t2);
      fq = ((64'd1 << 33) + den / 2) / den;
      f = fq > 64'h7fff_ffff ? 32'sh7fff_ffff : $signed(fq[31:0]);
      for (int i = 0; i < 3; i++) s[i] = prod_shift(t[i], f, 16);
      cross_prod(vm, t, c);
      for (int i = 0; i < 3; i++) vp[i] = clip_add(vm[i], c[i]);
      cross_prod(vp, s, c);
      for (int i = 0; i < 3; i++) res.v[i] = clip_add(clip_add(vm[i], c[i]), eh[i]);
      return res;
   endfunction

   function void note_particle(bvp_tb_pkg::particle_type p);
      pending_q.push_back(push(p));
   endfunction

   task report(string what);
      errors++;
      $display("MISMATCH %0t: %s", $realtime, what);
   endtask

   task check_velocity(logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z);
      bvp_tb_pkg::pushed_type exp_v;
      logic signed [31:0] got[3];
      got[0] = x;
      got[1] = y;
      got[2] = z;
      if (pending_q.size() == 0) begin
         report("velocity with no particle outstanding");
         return;
      end
      exp_v = pending_q.pop_front();
      checked++;
      for (int i = 0; i < 3; i++)
         if (got[i] !== exp_v.v[i])
            report($sformatf("component %0d got %h expected %h", i, got[i], exp_v.v[i]));
   endtask
endclass

module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bvp_pkg::*;
   import bvp_tb_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   word_type csr_wdata = '0;
   bit calm = 1'b0;
   int sent;
   push_scoreboard sb = new();

   bvp_req_if req ();
   bvp_rsp_if rsp ();

   boris_velocity_push_core u_dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .req(req.sink), .rsp(rsp.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req.valid = 1'b0;
      req.req_type = '0;
      {req.vel_in_x, req.vel_in_y, req.vel_in_z} = '0;
      {req.e_x, req.e_y, req.e_z, req.b_x, req.b_y, req.b_z} = '0;
      rsp.ready = 1'b0;
   end

   // Sink side: random back-pressure, none during the calm stretch.
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         sb.check_velocity(rsp.vel_out_x, rsp.vel_out_y, rsp.vel_out_z);
      rsp.ready <= !reset && (calm || $urandom_range(99) >= 18);
   end

   function automatic word_type pick_word(int scale);
      case ($urandom_range(9))
         0: return WMAX;
         1: return WMIN;
         2: return '0;
         3, 4: return word_type'($urandom);
         default: return word_type'($signed($urandom_range(2 * scale)) - scale);
      endcase
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, word_type val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_Q_OVER_M) sb.qm = val;
      else sb.dt = val;
   endtask

   // Valid stays high between back-to-back transactions; it drops only while
   // the sender idles or drains.
   task automatic send_particle(particle_type p);
      while (!calm && $urandom_range(99) < 18) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.req_type <= p.kind;
      req.vel_in_x <= p.v[0];
      req.vel_in_y <= p.v[1];
      req.vel_in_z <= p.v[2];
      req.e_x <= p.e[0];
      req.e_y <= p.e[1];
      req.e_z <= p.e[2];
      req.b_x <= p.b[0];
      req.b_y <= p.b[1];
      req.b_z <= p.b[2];
      do @(posedge clock); while (!req.ready);
      sb.note_particle(p);
      sent++;
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req.valid <= 1'b0;
      while (sb.pending_q.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (30) @(posedge clock);
   endtask

   task automatic random_batch(int n, int scale);
      particle_type p;
      for (int k = 0; k < n; k++) begin
         p.kind = 2'($urandom_range(3));
         for (int i = 0; i < 3; i++) begin
            p.v[i] = pick_word(scale);
            p.e[i] = pick_word(scale);
            p.b[i] = pick_word(scale);
         end
         case ($urandom_range(3))
            0: p.b = '{default: '0};
            1: begin
               p.e[2] = '0;
               p.b[0] = '0;
               p.b[1] = '0;
            end
            default: ;
         endcase
         send_particle(p);
      end
   endtask

   initial begin
      particle_type p;
      word_type qm_set[5] = '{32'sh0001_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                              -32'sh0000_8000, 32'sh0000_4000};
      word_type dt_set[5] = '{32'sh0001_0000, 32'sh8000_0000, 32'sh7fff_ffff,
                              32'sh0000_2000, -32'sh0001_0000};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: each step kind including the unused code, extremes, leapfrog, 2D.
      for (int k = 0; k < 4; k++) begin
         p.kind = 2'(k);
         p.v = '{32'sh0001_0000, -32'sh0002_0000, 32'sh0000_8000};
         p.e = '{32'sh0000_4000, 32'sh0001_0000, -32'sh0000_2000};
         p.b = '{32'sh0000_0000, 32'sh0000_0000, 32'sh0001_0000};
         send_particle(p);
         p.b = '{default: '0};
         send_particle(p);
      end
      p.kind = KIND_FULL;
      p.v = '{default: WMAX};
      p.e = '{default: WMAX};
      p.b = '{default: WMAX};
      send_particle(p);
      p.v = '{default: WMIN};
      p.e = '{default: WMIN};
      p.b = '{default: WMIN};
      send_particle(p);
      p.v = '{default: 32'shffff_ffff};
      p.e = '{default: 32'sh5555_5555};
      p.b = '{default: 32'shaaaa_aaaa};
      send_particle(p);
      p.v = '{default: '0};
      p.e = '{default: '0};
      p.b = '{default: '0};
      send_particle(p);
      drain();
      for (int ph = 0; ph < 5; ph++) begin
         write_reg(CSR_Q_OVER_M, qm_set[ph]);
         write_reg(CSR_TIME_STEP, dt_set[ph]);
         calm = (ph == 2);
         random_batch(200, 1 << (12 + 4 * ph));
         // The sender holds off here until every velocity is back.
         drain();
         calm = 1'b0;
         write_reg(CSR_Q_OVER_M, word_type'($urandom));
         write_reg(CSR_TIME_STEP, word_type'($urandom));
         random_batch(200, 1 << 20);
         drain();
      end
      $display("Sent %0d particles over 11 register settings; %0d velocities checked.",
               sent, sb.checked);
      if (sb.errors == 0 && sb.pending_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("DONE: errors detected");
      $finish;
   end
endmodule

@@ boris_velocity_push_core.f @@
+incdir+sv
sv/bvp_pkg.sv
sv/bvp_if.sv
sv/bvp_div.sv
sv/boris_velocity_push_core.sv
sim/bvp_tb_if.sv
sim/tb.sv
